// ----- sv/srr_pkg.sv -----
package srr_pkg;

  // Signed fixed-point working word for sine, cosine, matrix and spin terms.
  typedef logic signed [35:0] q_t;

  localparam q_t ONE_Q = 36'sd2147483648;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // One classified item as the front hands it to the back.
  typedef struct packed {
    logic             zero;
    logic [2:0][31:0] dmag;
    logic [2:0]       dneg;
    q_t   [2:0]       sv;
  } front_t;

endpackage

// ----- sv/spin_rodrigues_rotate.sv -----
// Channel | Ports                                   | Handshake
// --------+-----------------------------------------+--------------------------------
// input   | dir_x dir_y dir_z spin_x spin_y spin_z  | transfer when push && !full
// result  | rot_x rot_y rot_z                       | transfer when pop && !empty
//
// One item per cycle sustained while results are popped; a pipeline of 86 register
// stages, set by the 32-step square root and the 39-step sine/cosine series,
// runs from the queue to the result on the ports.
// Reset (rst, synchronous) empties the queue and drops every item in flight.
// A stalled result freezes the back pipeline; the front keeps filling the
// 4-entry queue until full rises.
module spin_rodrigues_rotate #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [DATA_WIDTH-1:0] dir_x,
  input  logic signed [DATA_WIDTH-1:0] dir_y,
  input  logic signed [DATA_WIDTH-1:0] dir_z,
  input  logic signed [DATA_WIDTH-1:0] spin_x,
  input  logic signed [DATA_WIDTH-1:0] spin_y,
  input  logic signed [DATA_WIDTH-1:0] spin_z,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [DATA_WIDTH-1:0] rot_x,
  output logic signed [DATA_WIDTH-1:0] rot_y,
  output logic signed [DATA_WIDTH-1:0] rot_z
);
  import srr_pkg::*;

  localparam int QW = $bits(front_t) + 3 * DATA_WIDTH;

  front_t                     fr_in, q_fr;
  logic [2:0][DATA_WIDTH-1:0] raw_in, q_raw;
  logic [QW-1:0]              q_rdata;
  logic                       q_empty;
  logic                       q_take;

  // Front: rescale and classify each item as it arrives.
  srr_front #(.DW(DATA_WIDTH)) u_front (
    .dir_x (dir_x),
    .dir_y (dir_y),
    .dir_z (dir_z),
    .spin_x(spin_x),
    .spin_y(spin_y),
    .spin_z(spin_z),
    .fr    (fr_in)
  );

  // Keep the raw spin so a zero rotation can hand it back bit for bit.
  assign raw_in[0] = spin_x;
  assign raw_in[1] = spin_y;
  assign raw_in[2] = spin_z;

  // Decouple the front from the back so each can stall on its own.
  srr_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (push),
    .wdata({raw_in, fr_in}),
    .full (full),
    .rd   (q_take),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign {q_raw, q_fr} = q_rdata;

  // Back: root, divides, sine/cosine, matrix and product in one pipeline.
  srr_back #(.DW(DATA_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .in_valid(!q_empty),
    .in_fr   (q_fr),
    .in_raw  (q_raw),
    .take    (q_take),
    .empty   (empty),
    .pop     (pop),
    .rot_x   (rot_x),
    .rot_y   (rot_y),
    .rot_z   (rot_z)
  );

`ifndef ASSERT_OFF
  a_full_has_entry: assert property (@(posedge clk) disable iff (rst)
    full |-> !q_empty)
    else $error("queue reports full with no entry");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  a_back_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |-> !q_take)
    else $error("back took an item while the result stalled");
`endif

endmodule

// ----- sv/srr_front.sv -----
module srr_front #(
  parameter int DW = 32
) (
  input  logic signed [DW-1:0] dir_x,
  input  logic signed [DW-1:0] dir_y,
  input  logic signed [DW-1:0] dir_z,
  input  logic signed [DW-1:0] spin_x,
  input  logic signed [DW-1:0] spin_y,
  input  logic signed [DW-1:0] spin_z,
  output srr_pkg::front_t      fr
);
  import srr_pkg::*;

  localparam int SL = (DW < 32) ? 32 - DW : 0;
  localparam int SR = (DW > 32) ? DW - 32 : 0;
  localparam int MW = DW + SL;

  // Split into sign and 32-bit magnitude, rescaled to the internal fraction.
  function automatic logic [32:0] conv(input logic [DW-1:0] v);
    logic [DW-1:0] mg;
    logic [MW-1:0] w;
    mg = v[DW-1] ? DW'(~v + 1'b1) : v;
    w = (MW'(mg) << SL) >> SR;
    conv = {v[DW-1], w[31:0]};
  endfunction

  logic [2:0][32:0] dc, sc;

  always_comb begin
    dc[0] = conv(dir_x);
    dc[1] = conv(dir_y);
    dc[2] = conv(dir_z);
    sc[0] = conv(spin_x);
    sc[1] = conv(spin_y);
    sc[2] = conv(spin_z);
    for (int i = 0; i < 3; i++) begin
      fr.dmag[i] = dc[i][31:0];
      fr.dneg[i] = dc[i][32];
      fr.sv[i]   = sc[i][32] ? -$signed({4'b0000, sc[i][31:0]})
                             : $signed({4'b0000, sc[i][31:0]});
    end
    // Classify: a vector that is zero after rescaling passes the spin through.
    fr.zero = (dc[0][31:0] == '0) && (dc[1][31:0] == '0) && (dc[2][31:0] == '0);
  end

endmodule

// ----- sv/srr_queue.sv -----
module srr_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic          we, re;

  assign full  = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign we    = wr && !full;
  assign re    = rd && !empty;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (we) begin
        wp <= wp + 1'b1;
      end
      if (re) begin
        rp <= rp + 1'b1;
      end
      if (we && !re) begin
        cnt <= cnt + 1'b1;
      end else if (re && !we) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ----- sv/srr_back.sv -----
module srr_back #(
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  srr_pkg::front_t      in_fr,
  input  logic [2:0][DW-1:0]   in_raw,
  output logic                 take,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [DW-1:0] rot_x,
  output logic signed [DW-1:0] rot_y,
  output logic signed [DW-1:0] rot_z
);
  import srr_pkg::*;

  typedef struct packed {
    front_t           fr;
    logic [2:0][63:0] rem;
    logic [63:0]      v;
    logic [63:0]      r;
    logic [31:0]      a;
    logic [32:0]      term;
    logic [32:0]      x;
    logic [65:0]      prod;
    logic [2:0][31:0] quo;
    q_t               sn;
    q_t               cs;
    q_t   [2:0]       tp;
    q_t   [8:0]       mm;
  } pipe_t;

  // Stage map.
  localparam int S_SQ   = 0;
  localparam int S_SUM  = 1;
  localparam int S_RT   = 2;
  localparam int S_INIT = S_RT + 32;
  localparam int S_TY   = S_INIT + 1;
  localparam int S_DB   = S_TY + 39;
  localparam int S_M1   = S_DB + 8;
  localparam int S_M2   = S_M1 + 1;
  localparam int NST    = S_M2 + 2;

  localparam int SL = (DW > 32) ? DW - 32 : 0;
  localparam int SR = (DW < 32) ? 32 - DW : 0;
  localparam int MW = 36 + SL;

  // floor(2^33 / n) for the Taylor divisions.
  localparam logic [32:0] RECIP [2:14] = '{
    33'd4294967296, 33'd2863311530, 33'd2147483648, 33'd1717986918,
    33'd1431655765, 33'd1227133513, 33'd1073741824, 33'd954437176,
    33'd858993459,  33'd780903144,  33'd715827882,  33'd660764199,
    33'd613566756
  };

  function automatic q_t mulq(input q_t a, input q_t b);
    logic [35:0] ma, mb;
    logic [71:0] p, rr;
    ma = a[35] ? 36'(-a) : 36'(a);
    mb = b[35] ? 36'(-b) : 36'(b);
    p  = 72'(ma) * 72'(mb);
    rr = (p + 72'd1073741824) >> 31;
    mulq = (a[35] ^ b[35]) ? -$signed(rr[35:0]) : $signed(rr[35:0]);
  endfunction

  function automatic logic [DW-1:0] store(input q_t acc);
    logic [35:0]   mg;
    logic [MW-1:0] m, lim;
    mg  = acc[35] ? 36'(-acc) : 36'(acc);
    m   = (MW'(mg) << SL) >> SR;
    lim = MW'(1) << (DW - 1);
    if (acc[35]) begin
      if (m > lim) begin
        m = lim;
      end
      m = MW'(0) - m;
    end else if (m > lim - 1'b1) begin
      m = lim - 1'b1;
    end
    store = m[DW-1:0];
  endfunction

  logic                  adv;
  logic                  vout;
  logic [NST-1:0]        vld;
  pipe_t                 pipe [NST];
  logic [2:0][DW-1:0]    rawp [NST];
  pipe_t                 head;
  q_t   [2:0]            acc;

  assign empty = !vout;
  assign adv   = !vout || pop;
  assign take  = adv && in_valid;

  always_comb begin
    head    = '0;
    head.fr = in_fr;
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    pipe_t p, n;
    if (k == 0) begin : g_head
      assign p = head;
    end else begin : g_prev
      assign p = pipe[k-1];
    end

    if (k == S_SQ) begin : g_sq
      always_comb begin
        n = p;
        for (int i = 0; i < 3; i++) begin
          n.rem[i] = 64'(p.fr.dmag[i]) * 64'(p.fr.dmag[i]);
        end
      end
    end else if (k == S_SUM) begin : g_sum
      always_comb begin
        n   = p;
        n.v = p.rem[0] + p.rem[1] + p.rem[2];
        n.r = '0;
      end
    end else if (k < S_INIT) begin : g_rt
      // One root bit per stage.
      localparam int J = k - S_RT;
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * J);
      always_comb begin
        n = p;
        if (p.v >= p.r + BIT) begin
          n.v = p.v - (p.r + BIT);
          n.r = (p.r >> 1) + BIT;
        end else begin
          n.r = p.r >> 1;
        end
      end
    end else if (k == S_INIT) begin : g_init
      always_comb begin
        n      = p;
        n.a    = {1'b0, p.r[31:1]};
        n.term = {2'b00, p.r[31:1]};
        n.sn   = $signed({5'b00000, p.r[31:1]});
        n.cs   = ONE_Q;
        n.quo  = '0;
        for (int i = 0; i < 3; i++) begin
          n.rem[i] = {1'b0, p.fr.dmag[i], 31'b0} + 64'(p.r[31:1]);
        end
      end
    end else if (k < S_DB) begin : g_ty
      // Taylor term in three steps, divider bit alongside for the first 32.
      localparam int T  = k - S_TY;
      localparam int NI = 2 + T / 3;
      localparam int PH = T % 3;
      localparam int DB = (T < 32) ? 31 - T : 0;
      always_comb begin
        logic [63:0] dsh;
        logic [32:0] q0, rr, tm;
        q_t          tq;
        n   = p;
        dsh = 64'(p.r[31:0]) << DB;
        q0  = p.prod[65:33];
        rr  = p.x - 33'(q0 * 33'(NI));
        tm  = (rr >= 33'(NI)) ? q0 + 33'd1 : q0;
        tq  = $signed({3'b000, tm});
        if (T < 32) begin
          for (int i = 0; i < 3; i++) begin
            if (p.rem[i] >= dsh) begin
              n.rem[i]     = p.rem[i] - dsh;
              n.quo[i][DB] = 1'b1;
            end
          end
        end
        if (PH == 0) begin
          n.x = 33'((64'(p.term) * 64'(p.a) + 64'd1073741824) >> 31);
        end else if (PH == 1) begin
          n.prod = 66'(p.x) * 66'(RECIP[NI]);
        end else begin
          n.term = tm;
          if ((NI % 4) == 2) begin
            n.cs = p.cs - tq;
          end else if ((NI % 4) == 3) begin
            n.sn = p.sn - tq;
          end else if ((NI % 4) == 0) begin
            n.cs = p.cs + tq;
          end else begin
            n.sn = p.sn + tq;
          end
        end
      end
    end else if (k < S_M1) begin : g_db
      // Angle doubling: products, then combine.
      localparam int DI = k - S_DB;
      always_comb begin
        n = p;
        if ((DI % 2) == 0) begin
          n.tp[0] = mulq(p.sn, p.cs);
          n.tp[1] = mulq(p.cs, p.cs);
          n.tp[2] = mulq(p.sn, p.sn);
        end else begin
          n.sn = p.tp[0] <<< 1;
          n.cs = p.tp[1] - p.tp[2];
        end
      end
    end else if (k == S_M1) begin : g_m1
      always_comb begin
        q_t u [3];
        n = p;
        for (int i = 0; i < 3; i++) begin
          u[i] = p.fr.dneg[i] ? -$signed({4'b0000, p.quo[i]})
                              : $signed({4'b0000, p.quo[i]});
        end
        n.mm[0] = mulq(u[2], u[2]);
        n.mm[1] = mulq(u[1], u[1]);
        n.mm[2] = mulq(u[0], u[0]);
        n.mm[3] = mulq(u[1], u[2]);
        n.mm[4] = mulq(u[0], u[2]);
        n.mm[5] = mulq(u[0], u[1]);
        n.mm[6] = mulq(u[0], p.sn);
        n.mm[7] = mulq(u[1], p.sn);
        n.mm[8] = mulq(u[2], p.sn);
      end
    end else if (k == S_M2) begin : g_m2
      always_comb begin
        q_t dd, s1, s2, s3;
        n  = p;
        dd = ONE_Q - p.cs;
        s1 = -mulq(p.mm[3], dd);
        s2 = mulq(p.mm[4], dd);
        s3 = -mulq(p.mm[5], dd);
        n.mm[0] = p.cs + mulq(p.mm[0], dd);
        n.mm[4] = p.cs + mulq(p.mm[1], dd);
        n.mm[8] = p.cs + mulq(p.mm[2], dd);
        n.mm[1] = s1 + p.mm[6];
        n.mm[3] = s1 - p.mm[6];
        n.mm[2] = s2 + p.mm[7];
        n.mm[6] = s2 - p.mm[7];
        n.mm[5] = s3 + p.mm[8];
        n.mm[7] = s3 - p.mm[8];
      end
    end else begin : g_m3
      // Row vector times matrix: term j of output i lands at 3*i+j.
      always_comb begin
        n = p;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            n.mm[3*i+j] = mulq(p.mm[3*j+i], p.fr.sv[j]);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[k] <= n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rawp[0] <= in_raw;
      for (int k = 1; k < NST; k++) begin
        rawp[k] <= rawp[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = pipe[NST-1].mm[3*i] + pipe[NST-1].mm[3*i+1] + pipe[NST-1].mm[3*i+2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      vout <= 1'b0;
    end else if (adv) begin
      vld  <= {vld[NST-2:0], in_valid};
      vout <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pipe[NST-1].fr.zero) begin
        rot_x <= rawp[NST-1][0];
        rot_y <= rawp[NST-1][1];
        rot_z <= rawp[NST-1][2];
      end else begin
        rot_x <= store(acc[0]);
        rot_y <= store(acc[1]);
        rot_z <= store(acc[2]);
      end
    end
  end

endmodule
